>>> rtl/pal_argb_pkg.sv
// Shared constants for the palette index to ARGB unit.
package pal_argb_pkg;

    // Palette geometry.
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);

    // Field widths.
    localparam int IDX_W       = 8;
    localparam int RGB_W       = 24;
    localparam int PIX_W       = 32;
    localparam int SIZE_W      = 9;
    localparam int IN_TDATA_W  = 40;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 9;

    // Embedded palette limits.
    localparam logic [SIZE_W-1:0] MAX_PAL_SIZE     = 9'd256;
    localparam logic [SIZE_W-1:0] PAL_DEPTH_W      = SIZE_W'(PAL_DEPTH);
    localparam logic [IDX_W-1:0]  FULLBRIGHT_FIRST = 8'd224;
    localparam logic [7:0]        ALPHA_OPAQUE     = 8'hff;

    // Request kinds carried in the input tuser bit.
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_FORMAT_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAL_SIZE    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LAST_TRANSP = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FULLBRIGHT  = 2'd3;

endpackage

>>> rtl/palette_index_to_argb_unit.sv
// Palette index to ARGB expansion pipeline with embedded palette memory.

// Each request on the input stream either writes one 24-bit RGB entry into the
// palette (tuser low) or converts one 8-bit index into a 32-bit ARGB pixel
// (tuser high). The unit is a three-stage pipeline that takes one request per
// clock while the output does not stall; a convert request passes through the
// request, palette-read and output registers, and write requests produce no
// output and simply leave the pipeline. The sustained rate of one request per
// cycle is set by the single palette memory, which is read or written once per
// cycle in the second stage, so a convert that follows a write to the same slot
// in the next cycle already sees the new entry. Back-pressure on the output
// stalls the whole pipeline without losing or repeating a request. Entries that
// were never written read back as whatever the memory holds. In embedded mode
// an index at or past the palette size gives zero, the last entry can be made
// transparent, and indices from 224 up can get alpha zero; a palette size of
// zero or above 256 gives a zero pixel with the error flag in the output tuser.
// Configuration must only be written while no convert request is in flight.
module palette_index_to_argb_unit
    import pal_argb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Request stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0 up: palette_slot[7:0], entry_rgb[31:8], color_index[39:32].
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // Fields: cmd[0].
    input  logic                  s_axis_tuser,

    // Pixel stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields: pixel_argb[31:0].
    output logic [PIX_W-1:0]      m_axis_tdata,
    // Fields: palette_error[0].
    output logic                  m_axis_tuser
);

    // Configuration registers; they take writes at any time.
    logic              format_mode_reg;
    logic [SIZE_W-1:0] pal_size_reg;
    logic              last_transp_reg;
    logic              fullbright_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= 1'b1;
            pal_size_reg    <= MAX_PAL_SIZE;
            last_transp_reg <= 1'b0;
            fullbright_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                CFG_FORMAT_MODE: format_mode_reg <= cfg_data[0];
                CFG_PAL_SIZE:    pal_size_reg    <= cfg_data[SIZE_W-1:0];
                CFG_LAST_TRANSP: last_transp_reg <= cfg_data[0];
                CFG_FULLBRIGHT:  fullbright_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Stage valid bits and per-stage ready, computed from the output backward.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3 = !s3_valid_reg || m_axis_tready;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;
    assign s_axis_tready = rdy1;

    // Stage 1: registered request.
    logic              s1_cmd_reg;
    logic [IDX_W-1:0]  s1_slot_reg;
    logic [RGB_W-1:0]  s1_rgb_reg;
    logic [IDX_W-1:0]  s1_idx_reg;

    // Stage 2: palette read data and decoded pixel rules.
    logic [RGB_W-1:0]  rd_rgb_reg;
    logic              s2_zero_reg;
    logic              s2_alpha_zero_reg;
    logic              s2_err_reg;

    // Stage 3: output register.
    logic [PIX_W-1:0]  s3_pixel_reg;
    logic              s3_err_reg;

    logic s1_adv, s2_adv, s3_adv;
    assign s1_adv = s_axis_tvalid && rdy1;
    assign s2_adv = s1_valid_reg && rdy2;
    assign s3_adv = s2_valid_reg && rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            // Write requests retire at the memory and do not move on.
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg && (s1_cmd_reg == CMD_CONVERT);
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_cmd_reg  <= s_axis_tuser;
            s1_slot_reg <= s_axis_tdata[7:0];
            s1_rgb_reg  <= s_axis_tdata[31:8];
            s1_idx_reg  <= s_axis_tdata[39:32];
        end
    end

    // Palette memory: one write or one read per cycle.
    logic [RGB_W-1:0] palette_mem_reg [PAL_DEPTH];
    logic             mem_wr;
    logic             mem_rd;
    logic [SIZE_W-1:0] slot_ext;
    logic [SIZE_W-1:0] idx_ext;

    assign slot_ext = {1'b0, s1_slot_reg};
    assign idx_ext  = {1'b0, s1_idx_reg};
    assign mem_wr   = s2_adv && (s1_cmd_reg == CMD_WRITE) && (slot_ext < PAL_DEPTH_W);
    assign mem_rd   = s2_adv && (s1_cmd_reg == CMD_CONVERT);

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            palette_mem_reg[s1_slot_reg[PAL_AW-1:0]] <= s1_rgb_reg;
        end
        if (mem_rd)
        begin
            rd_rgb_reg <= palette_mem_reg[s1_idx_reg[PAL_AW-1:0]];
        end
    end

    // Pixel rules decided beside the memory read.
    logic size_bad;
    logic idx_past_depth;
    logic zero_next;
    logic alpha_zero_next;
    logic err_next;

    always_comb
    begin
        size_bad       = (pal_size_reg == '0) || (pal_size_reg > MAX_PAL_SIZE);
        idx_past_depth = idx_ext >= PAL_DEPTH_W;
        if (!format_mode_reg)
        begin
            err_next        = 1'b0;
            zero_next       = idx_past_depth;
            alpha_zero_next = 1'b0;
        end
        else
        begin
            err_next        = size_bad;
            zero_next       = size_bad || idx_past_depth || (idx_ext >= pal_size_reg)
                              || (last_transp_reg && (idx_ext == pal_size_reg - 9'd1));
            alpha_zero_next = fullbright_reg && (s1_idx_reg >= FULLBRIGHT_FIRST);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            s2_zero_reg       <= zero_next;
            s2_alpha_zero_reg <= alpha_zero_next;
            s2_err_reg        <= err_next;
        end
    end

    // Final pixel assembly.
    logic [PIX_W-1:0] pixel_next;

    always_comb
    begin
        if (s2_zero_reg)
        begin
            pixel_next = '0;
        end
        else
        begin
            pixel_next = {(s2_alpha_zero_reg ? 8'h00 : ALPHA_OPAQUE), rd_rgb_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            s3_pixel_reg <= pixel_next;
            s3_err_reg   <= s2_err_reg;
        end
    end

    assign m_axis_tvalid = s3_valid_reg;
    assign m_axis_tdata  = s3_pixel_reg;
    assign m_axis_tuser  = s3_err_reg;

endmodule

>>> rtl/pal_argb_chk.sv
// Port-level checks for the palette index to ARGB unit, bound to the top level.
module pal_argb_chk
    import pal_argb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [PIX_W-1:0]      m_axis_tdata,
    input logic                  m_axis_tuser
);

    // A stalled pixel stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled pixel changed or dropped");

    // A palette size error always comes with a zero pixel.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error flag with nonzero pixel");

    // Alpha is either fully opaque or fully transparent.
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'h00 || m_axis_tdata[31:24] == ALPHA_OPAQUE))
        else $error("alpha byte neither 0x00 nor 0xff");

    // Configuration writes are never held off.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind palette_index_to_argb_unit pal_argb_chk u_pal_argb_chk (.*);

>>> sim/tb_top.sv
// Self-checking testbench for the palette index to ARGB expansion unit.
module tb_top;
    import pal_argb_pkg::*;

    // Pipeline depth from the unit's description; used to let in-flight
    // palette writes settle before the configuration changes.
    localparam int PIPE_LATENCY = 3;
    localparam int SETTLE_CYCLES = 2 * PIPE_LATENCY + 2;
    // Length of the one long output stall, and the watchdog limit on cycles
    // with no accepted request on any channel.
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    // Total number of requests sent over the whole run.
    localparam int TOTAL_ITEMS = 1950;

    // Values of the format mode register.
    localparam logic FMT_FIXED    = 1'b0;
    localparam logic FMT_EMBEDDED = 1'b1;
    localparam logic [7:0] ALPHA_CLEAR = 8'h00;

    // One request on the input stream.
    typedef struct {
        logic              cmd;
        logic [IDX_W-1:0]  slot;
        logic [RGB_W-1:0]  rgb;
        logic [IDX_W-1:0]  index;
    } pixel_req_t;

    // One pixel on the output stream.
    typedef struct {
        logic [PIX_W-1:0] argb;
        logic             err;
    } pixel_out_t;

    // Shadow copy of the palette and the configuration. It predicts the
    // pixel for every accepted convert request and checks the pixels that
    // come out against those predictions in order.
    class palette_shadow;
        logic [RGB_W-1:0]  palette [PAL_DEPTH];
        logic              fmt_mode;
        logic [SIZE_W-1:0] pal_size;
        logic              last_transp;
        logic              fullbright;
        pixel_out_t        pending_pixels [$];
        int                errors;

        function new();
            fmt_mode    = FMT_EMBEDDED;
            pal_size    = MAX_PAL_SIZE;
            last_transp = 1'b0;
            fullbright  = 1'b0;
            errors      = 0;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                CFG_FORMAT_MODE: fmt_mode    = data[0];
                CFG_PAL_SIZE:    pal_size    = data[SIZE_W-1:0];
                CFG_LAST_TRANSP: last_transp = data[0];
                CFG_FULLBRIGHT:  fullbright  = data[0];
                default: ;
            endcase
        endfunction

        function pixel_out_t expand_index(logic [IDX_W-1:0] idx);
            pixel_out_t o;
            logic [7:0] alpha;
            o.argb = '0;
            o.err  = 1'b0;
            if (fmt_mode == FMT_FIXED)
            begin
                if (int'(idx) < PAL_DEPTH)
                    o.argb = {ALPHA_OPAQUE, palette[idx]};
            end
            else if (pal_size == '0 || pal_size > MAX_PAL_SIZE)
            begin
                o.err = 1'b1;
            end
            else if (SIZE_W'(idx) >= pal_size || int'(idx) >= PAL_DEPTH)
            begin
                o.argb = '0;
            end
            else if (last_transp && SIZE_W'(idx) == pal_size - 1'b1)
            begin
                o.argb = '0;
            end
            else
            begin
                alpha = (fullbright && idx >= FULLBRIGHT_FIRST) ? ALPHA_CLEAR : ALPHA_OPAQUE;
                o.argb = {alpha, palette[idx]};
            end
            return o;
        endfunction

        function void note_request(pixel_req_t r);
            if (r.cmd == CMD_WRITE)
            begin
                if (int'(r.slot) < PAL_DEPTH)
                    palette[r.slot] = r.rgb;
            end
            else
            begin
                pending_pixels.push_back(expand_index(r.index));
            end
        endfunction

        function void check_pixel(logic [PIX_W-1:0] argb, logic err);
            pixel_out_t want;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: ERROR pixel with no request waiting, actual argb %08h err %0b",
                         $time, argb, err);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (argb !== want.argb)
            begin
                $display("%0t: ERROR pixel_argb expected %08h actual %08h",
                         $time, want.argb, argb);
                errors++;
            end
            if (err !== want.err)
            begin
                $display("%0t: ERROR palette_error expected %0b actual %0b",
                         $time, want.err, err);
                errors++;
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // Fields from bit 0 up: palette_slot[7:0], entry_rgb[31:8], color_index[39:32].
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    // Fields: cmd[0].
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // Fields: pixel_argb[31:0].
    logic [PIX_W-1:0]      m_axis_tdata;
    // Fields: palette_error[0].
    logic                  m_axis_tuser;

    palette_shadow shadow = new();

    // Sender burst state: requests left in the current burst, and whether
    // the current phase runs with no gaps at all.
    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    int          items_sent = 0;
    logic [IDX_W-1:0] last_slot = '0;

    // The stimulus raises this once; the receiver answers with one long stall
    // and marks it done, so each flag has a single writer.
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;

    palette_index_to_argb_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offers one request and returns right after the edge that accepted it.
    // Handshake signals are sampled just after the edge, before any of this
    // edge's register updates land, so they hold the values the unit saw.
    task automatic send_item(input pixel_req_t r);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.index, r.rgb, r.slot};
        s_axis_tuser  <= r.cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        shadow.note_request(r);
        items_sent++;
    endtask

    task automatic idle_input(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sends a request as part of a burst. When a burst runs out, a random gap
    // (possibly zero) goes in before the next one starts, unless the current phase runs with no gaps.
    task automatic offer(input pixel_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (!no_gaps && gap > 0)
                idle_input(gap);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_item(r);
    endtask

    task automatic write_entry(input logic [IDX_W-1:0] slot, input logic [RGB_W-1:0] rgb);
        pixel_req_t r;
        r.cmd   = CMD_WRITE;
        r.slot  = slot;
        r.rgb   = rgb;
        r.index = IDX_W'($urandom);
        offer(r);
    endtask

    // Convert requests carry random junk in the fields they do not use.
    task automatic convert(input logic [IDX_W-1:0] idx);
        pixel_req_t r;
        r.cmd   = CMD_CONVERT;
        r.slot  = IDX_W'($urandom);
        r.rgb   = RGB_W'($urandom);
        r.index = idx;
        offer(r);
    endtask

    // Stops offering, waits for every predicted pixel to come out, and then
    // gives trailing palette writes time to leave the pipeline.
    task automatic drain();
        idle_input(1);
        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers back to back; valid drops only after the
    // last one so it is never lowered and raised in the same step.
    task automatic write_config(input logic fm, input logic [SIZE_W-1:0] size,
                                input logic lt, input logic fb);
        logic [CFG_ADDR_W-1:0] addrs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        addrs[0] = CFG_FORMAT_MODE; vals[0] = CFG_DATA_W'(fm);
        addrs[1] = CFG_PAL_SIZE;    vals[1] = CFG_DATA_W'(size);
        addrs[2] = CFG_LAST_TRANSP; vals[2] = CFG_DATA_W'(lt);
        addrs[3] = CFG_FULLBRIGHT;  vals[3] = CFG_DATA_W'(fb);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            shadow.set_register(addrs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic new_setting(input logic fm, input logic [SIZE_W-1:0] size,
                               input logic lt, input logic fb);
        drain();
        write_config(fm, size, lt, fb);
    endtask

    // Index choice leans on the edges of the current setting: the last
    // valid entry, the first one past the size, the fullbright boundary,
    // both ends of the range, and the slot written most recently.
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned sel;
        logic [IDX_W-1:0] idx;
        sel = $urandom_range(0, 11);
        case (sel)
            0: idx = IDX_W'(shadow.pal_size - 1'b1);
            1: idx = IDX_W'(shadow.pal_size);
            2: idx = FULLBRIGHT_FIRST - 1'b1;
            3: idx = FULLBRIGHT_FIRST;
            4: idx = '1;
            5: idx = '0;
            6, 7: idx = last_slot;
            default: idx = IDX_W'($urandom);
        endcase
        return idx;
    endfunction

    function automatic pixel_req_t random_request();
        pixel_req_t r;
        r.slot  = IDX_W'($urandom);
        r.rgb   = RGB_W'($urandom);
        r.index = IDX_W'($urandom);
        r.cmd   = ($urandom_range(0, 3) == 0) ? CMD_WRITE : CMD_CONVERT;
        if (r.cmd == CMD_CONVERT)
            r.index = pick_index();
        else
            last_slot = r.slot;
        return r;
    endfunction

    // Receiver. It stalls on a pattern that changes from segment to segment:
    // always ready, coin flip, one cycle in four, or mostly ready. When the
    // stimulus asks for it, it holds off for a long stretch so the pipeline
    // fills and the unit has to stall its input.
    initial
    begin : receiver
        int seg_left;
        int mode;
        int hold_left;
        int cyc;
        logic ready_next;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        cyc       = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                shadow.check_pixel(m_axis_tdata, m_axis_tuser);
            cyc++;
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(16, 128);
            end
            seg_left--;
            case (mode)
                0: ready_next = 1'b1;
                1: ready_next = 1'($urandom_range(0, 1));
                2: ready_next = (cyc % 4 == 0);
                default: ready_next = ($urandom_range(0, 9) != 0);
            endcase
            if (hold_left > 0)
            begin
                ready_next = 1'b0;
                hold_left--;
            end
            m_axis_tready <= ready_next;
        end
    end

    // Watchdog: counts consecutive cycles with no accepted request on any of
    // the three channels and ends the run when the count reaches the limit.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: ERROR no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL palette_index_to_argb_unit");
        $finish;
    end

    initial
    begin : stimulus
        logic              fm;
        logic [SIZE_W-1:0] size;
        logic              lt;
        logic              fb;
        int                phase;

        // Reset is held low from the start and released at a clock edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every palette entry first, so no later lookup can touch an
        // entry that was never written.
        for (int s = 0; s < PAL_DEPTH; s++)
            write_entry(IDX_W'(s), RGB_W'($urandom));

        // Directed part. Reset setting: embedded, full size, no flags.
        new_setting(FMT_EMBEDDED, MAX_PAL_SIZE, 1'b0, 1'b0);
        convert(8'd0);
        convert(8'd255);
        convert(FULLBRIGHT_FIRST);
        // A convert right behind a write to the same slot must see the new entry.
        no_gaps = 1'b1;
        write_entry(8'd7, 24'hffffff);
        convert(8'd7);
        no_gaps = 1'b0;

        // Fixed mode ignores both flags.
        new_setting(FMT_FIXED, MAX_PAL_SIZE, 1'b1, 1'b1);
        convert(8'd0);
        convert(8'd255);
        convert(FULLBRIGHT_FIRST);

        // Short embedded palette: last entry transparent, indices past the
        // size give zero, including ones in the fullbright range.
        new_setting(FMT_EMBEDDED, 9'd100, 1'b1, 1'b1);
        convert(8'd99);
        convert(8'd98);
        convert(8'd100);
        convert(FULLBRIGHT_FIRST);
        convert(8'd0);

        // Full palette with both flags: the fullbright boundary and the
        // transparent last entry.
        new_setting(FMT_EMBEDDED, MAX_PAL_SIZE, 1'b1, 1'b1);
        convert(8'd255);
        convert(8'd254);
        convert(FULLBRIGHT_FIRST);
        convert(FULLBRIGHT_FIRST - 1'b1);

        // Bad palette sizes: zero, just past the maximum, and all ones.
        new_setting(FMT_EMBEDDED, 9'd0, 1'b0, 1'b0);
        convert(8'd5);
        new_setting(FMT_EMBEDDED, 9'd257, 1'b0, 1'b0);
        convert(8'd0);
        new_setting(FMT_EMBEDDED, 9'd511, 1'b1, 1'b1);
        convert(8'd255);

        // One-entry palette, with and without the transparent last entry.
        new_setting(FMT_EMBEDDED, 9'd1, 1'b1, 1'b0);
        convert(8'd0);
        convert(8'd1);
        new_setting(FMT_EMBEDDED, 9'd1, 1'b0, 1'b1);
        convert(8'd0);

        // Random part: phases of random length, each under a random setting
        // that favors the edges of the size range, until the total request
        // count is reached. Every phase ends with a full drain, so the sender
        // also pauses until all pixels are out.
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            fm = ($urandom_range(0, 4) == 0) ? FMT_FIXED : FMT_EMBEDDED;
            case ($urandom_range(0, 9))
                0, 1: size = MAX_PAL_SIZE;
                2:    size = '0;
                3:    size = 9'd1;
                4:    size = SIZE_W'($urandom_range(257, 511));
                5:    size = 9'd2;
                default: size = SIZE_W'($urandom_range(2, 255));
            endcase
            lt = 1'($urandom_range(0, 1));
            fb = 1'($urandom_range(0, 1));
            new_setting(fm, size, lt, fb);
            no_gaps = ($urandom_range(0, 4) == 0);
            // In one phase the receiver stalls for a long time while the
            // sender keeps offering.
            if (phase == 2)
                hold_request = 1'b1;
            for (int i = $urandom_range(80, 200); i > 0 && items_sent < TOTAL_ITEMS; i--)
            begin
                offer(random_request());
            end
            phase++;
        end

        drain();
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("PASS palette_index_to_argb_unit");
        else
            $display("FAIL palette_index_to_argb_unit");
        $finish;
    end

endmodule
